// File: design/software_timer_bank_macros.svh
`ifndef SOFTWARE_TIMER_BANK_MACROS_SVH
`define SOFTWARE_TIMER_BANK_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define STB_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define STB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/stb_pkg.sv
`default_nettype none

package stb_pkg;

   localparam int PRESC_W     = 10;
   localparam int COUNT_W     = 32;
   localparam int MAX_RESULTS = 8;
   localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);
   localparam int REQ_DATA_W  = 40;
   localparam int RSP_DATA_W  = 8;

   typedef enum logic [1:0] {
      OP_TICK     = 2'd0,
      OP_CREATE   = 2'd1,
      OP_ACTIVATE = 2'd2,
      OP_RESERVED = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_FLUSH
   } state_type;

   // One timer's counters and settings as held in the slot memory.
   typedef struct packed {
      logic               handler;
      logic               seconds;
      logic [PRESC_W-1:0] presc;
      logic [COUNT_W-1:0] progress;
      logic [COUNT_W-1:0] target;
   } entry_type;

   // Result beat, slot in the lowest bits.
   typedef struct packed {
      logic       no_free;
      logic       created;
      logic       fired;
      logic [2:0] slot;
   } rsp_item_type;

endpackage

`default_nettype wire

// File: design/software_timer_bank.sv
// Create and activate: the single result beat, with tlast, goes through the held register and
// then the output register once that is free; an activate of an unknown or uncreated slot gives none.
// Tick: the slot memory is walked one slot per cycle while the result side keeps up; a firing
// to report stalls the walk while a held result beat is waiting for a free output.
// A new request beat is taken only when the previous one has finished its walk or update.
// Reset (synchronous, active high) clears the enabled, active and reload flags of every slot;
// the slot memory is not cleared, since create writes a whole entry before it is ever used.
`default_nettype none
`include "software_timer_bank_macros.svh"

module software_timer_bank
   import stb_pkg::*;
#(
   parameter int TIMERS           = 8,
   parameter int TICKS_PER_SECOND = 1000
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output      logic                  req_tready,
   // [2:0] timer_index, [3] seconds_mode, [35:4] alarm_count, [36] has_handler,
   // [37] reload, [39:38] zero
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // [1:0] operation
   input  wire logic [1:0]            req_tuser,
   output      logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [2:0] slot, [3] fired, [4] created, [5] no_free_slot, [7:6] zero
   output      logic [RSP_DATA_W-1:0] rsp_tdata,
   output      logic                  rsp_tlast
);

   localparam int SLOT_W = (TIMERS > 1) ? $clog2(TIMERS) : 1;

   state_type          state_ff, state_in;
   logic [SLOT_W-1:0]  idx_ff, idx_in;
   logic [RES_CNT_W-1:0] rep_cnt_ff, rep_cnt_in;
   logic               held_valid_ff, held_valid_in;
   rsp_item_type       held_ff, held_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_item_type       rsp_data_ff, rsp_data_in;
   logic               rsp_last_ff, rsp_last_in;
   logic [TIMERS-1:0]  enabled_ff, enabled_in;
   logic [TIMERS-1:0]  active_ff, active_in;
   logic [TIMERS-1:0]  reload_ff, reload_in;

   logic               ram_we;
   logic [SLOT_W-1:0]  ram_waddr;
   entry_type          ram_wdata;
   logic               ram_re;
   logic [SLOT_W-1:0]  ram_raddr;
   entry_type          ram_rdata;

   op_type             req_op;
   logic [2:0]         req_index;
   logic               req_seconds;
   logic [COUNT_W-1:0] req_alarm;
   logic               req_handler;
   logic               req_reload;

   logic               free_found;
   logic [SLOT_W-1:0]  free_idx;
   logic               act_ok;
   logic [SLOT_W-1:0]  act_slot;
   logic               out_free;

   logic [PRESC_W:0]   presc_inc;
   logic [PRESC_W:0]   presc_limit;
   logic               roll;
   logic [COUNT_W-1:0] prog_inc;
   logic               fire;
   logic               slot_act;
   logic               report;
   logic               advance;
   entry_type          upd_entry;

   assign req_op      = op_type'(req_tuser);
   assign req_index   = req_tdata[2:0];
   assign req_seconds = req_tdata[3];
   assign req_alarm   = req_tdata[35:4];
   assign req_handler = req_tdata[36];
   assign req_reload  = req_tdata[37];

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_data_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Lowest slot that has not been claimed yet.
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = TIMERS - 1; i >= 0; i--) begin
         if (!enabled_ff[i]) begin
            free_found = 1'b1;
            free_idx   = SLOT_W'(i);
         end
      end
   end

   assign act_slot = SLOT_W'(req_index);
   assign act_ok   = (32'(req_index) < 32'(TIMERS)) && enabled_ff[act_slot];

   // Per-slot update during the tick walk; the memory output belongs to slot idx_ff.
   always_comb begin
      presc_inc   = {1'b0, ram_rdata.presc} + (PRESC_W + 1)'(1);
      presc_limit = ram_rdata.seconds ? (PRESC_W + 1)'(TICKS_PER_SECOND)
                                      : (PRESC_W + 1)'(1);
      roll        = !(presc_inc < presc_limit);
      prog_inc    = ram_rdata.progress + COUNT_W'(1);
      fire        = roll && ram_rdata.handler && (prog_inc >= ram_rdata.target);
      upd_entry   = ram_rdata;
      upd_entry.presc    = roll ? '0 : presc_inc[PRESC_W-1:0];
      upd_entry.progress = fire ? '0 : (roll ? prog_inc : ram_rdata.progress);
      slot_act    = active_ff[idx_ff];
      report      = slot_act && fire && (rep_cnt_ff < RES_CNT_W'(MAX_RESULTS));
      // A firing is held back one beat so that the final one can carry tlast.
      advance     = !(report && held_valid_ff) || out_free;
   end

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      rep_cnt_in    = rep_cnt_ff;
      held_valid_in = held_valid_ff;
      held_in       = held_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;
      enabled_in    = enabled_ff;
      active_in     = active_ff;
      reload_in     = reload_ff;
      ram_we        = 1'b0;
      ram_waddr     = idx_ff;
      ram_wdata     = upd_entry;
      ram_re        = 1'b0;
      ram_raddr     = idx_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               unique case (req_op)
                  OP_TICK: begin
                     ram_re        = 1'b1;
                     ram_raddr     = '0;
                     idx_in        = '0;
                     rep_cnt_in    = '0;
                     held_valid_in = 1'b0;
                     state_in      = ST_EVAL;
                  end
                  OP_CREATE: begin
                     if (free_found) begin
                        ram_we             = 1'b1;
                        ram_waddr          = free_idx;
                        ram_wdata.handler  = req_handler;
                        ram_wdata.seconds  = req_seconds;
                        ram_wdata.presc    = '0;
                        ram_wdata.progress = '0;
                        ram_wdata.target   = req_alarm;
                        enabled_in[free_idx] = 1'b1;
                        active_in[free_idx]  = 1'b0;
                        reload_in[free_idx]  = 1'b0;
                        held_in = '{no_free: 1'b0, created: 1'b1, fired: 1'b0,
                                    slot: 3'(free_idx)};
                     end else begin
                        held_in = '{no_free: 1'b1, created: 1'b0, fired: 1'b0,
                                    slot: 3'd0};
                     end
                     held_valid_in = 1'b1;
                     state_in      = ST_FLUSH;
                  end
                  OP_ACTIVATE: begin
                     if (act_ok) begin
                        active_in[act_slot] = 1'b1;
                        reload_in[act_slot] = req_reload;
                        held_in = '{no_free: 1'b0, created: 1'b0, fired: 1'b0,
                                    slot: req_index};
                        held_valid_in = 1'b1;
                        state_in      = ST_FLUSH;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_EVAL: begin
            if (advance) begin
               if (slot_act) begin
                  ram_we    = 1'b1;
                  ram_waddr = idx_ff;
                  ram_wdata = upd_entry;
                  if (fire && !reload_ff[idx_ff]) begin
                     active_in[idx_ff] = 1'b0;
                  end
               end
               if (report) begin
                  if (held_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = held_ff;
                     rsp_last_in  = 1'b0;
                  end
                  held_in = '{no_free: 1'b0, created: 1'b0, fired: 1'b1,
                              slot: 3'(idx_ff)};
                  held_valid_in = 1'b1;
                  rep_cnt_in    = rep_cnt_ff + RES_CNT_W'(1);
               end
               if (idx_ff == SLOT_W'(TIMERS - 1)) begin
                  state_in = ST_FLUSH;
               end else begin
                  idx_in    = idx_ff + SLOT_W'(1);
                  ram_re    = 1'b1;
                  ram_raddr = idx_ff + SLOT_W'(1);
               end
            end
         end

         ST_FLUSH: begin
            if (!held_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = held_ff;
               rsp_last_in   = 1'b1;
               held_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         idx_ff        <= '0;
         rep_cnt_ff    <= '0;
         held_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         enabled_ff    <= '0;
         active_ff     <= '0;
         reload_ff     <= '0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         rep_cnt_ff    <= rep_cnt_in;
         held_valid_ff <= held_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         enabled_ff    <= enabled_in;
         active_ff     <= active_in;
         reload_ff     <= reload_in;
      end
   end

   always_ff @(posedge clock) begin
      held_ff     <= held_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   stb_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (TIMERS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   `STB_ASSERT_IMP(a_active_needs_enabled, clock, reset, 1'b1,
      (active_ff & ~enabled_ff) == '0, "an active slot was never created")
   `STB_ASSERT_NEXT(a_enabled_sticky, clock, reset, 1'b1,
      (enabled_ff & $past(enabled_ff)) == $past(enabled_ff), "a created slot was released")
   `STB_ASSERT_IMP(a_one_flag, clock, reset, rsp_valid_ff,
      $onehot0({rsp_data_ff.fired, rsp_data_ff.created, rsp_data_ff.no_free}),
      "result beat reports more than one outcome")
   `STB_ASSERT_IMP(a_report_cap, clock, reset, state_ff == ST_EVAL,
      rep_cnt_ff <= RES_CNT_W'(MAX_RESULTS), "more firings reported than allowed")
   `STB_ASSERT_IMP(a_write_owner, clock, reset, ram_we,
      state_ff == ST_EVAL || (state_ff == ST_IDLE && req_tvalid && req_op == OP_CREATE),
      "slot memory written outside a create or a tick walk")

endmodule

`default_nettype wire

// File: design/stb_ram.sv
`default_nettype none

module stb_ram #(
   parameter  int WIDTH  = 8,
   parameter  int DEPTH  = 8,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                   clock,
   input  wire logic                   wr_en,
   input  wire logic [ADDR_W-1:0]      wr_addr,
   input  wire logic [WIDTH-1:0]       wr_data,
   input  wire logic                   rd_en,
   input  wire logic [ADDR_W-1:0]      rd_addr,
   output      logic [WIDTH-1:0]       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire
